>>> rtl/isle_pkg.sv
package isle_pkg;

   localparam int ISLE_DEPTH  = 64;
   localparam int ISLE_DATA_W = 32;
   localparam int CMD_W       = 3;
   localparam int PC_W        = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

   // Sequencing of the next step.
   localparam logic [2:0] NX_SEQ  = 3'd0;
   localparam logic [2:0] NX_JMP  = 3'd1;
   localparam logic [2:0] NX_CJMP = 3'd2;
   localparam logic [2:0] NX_DISP = 3'd3;
   localparam logic [2:0] NX_FIN  = 3'd4;

   // Jump conditions.
   localparam logic [1:0] COND_EQ_IDX  = 2'd0;
   localparam logic [1:0] COND_IS_READ = 2'd1;
   localparam logic [1:0] COND_LAST    = 2'd2;

   // Read address select.
   localparam logic [1:0] RA_PTR_M1 = 2'd0;
   localparam logic [1:0] RA_IDX    = 2'd1;
   localparam logic [1:0] RA_PTR_P1 = 2'd2;
   localparam logic [1:0] RA_OTH    = 2'd3;

   // Write address select.
   localparam logic [1:0] WA_PTR = 2'd0;
   localparam logic [1:0] WA_IDX = 2'd1;
   localparam logic [1:0] WA_OTH = 2'd2;

   // Write data select.
   localparam logic [1:0] WD_RD   = 2'd0;
   localparam logic [1:0] WD_WORD = 2'd1;
   localparam logic [1:0] WD_TMP  = 2'd2;

   // Pointer operations.
   localparam logic [2:0] PTR_HOLD   = 3'd0;
   localparam logic [2:0] PTR_LD_CNT = 3'd1;
   localparam logic [2:0] PTR_LD_IDX = 3'd2;
   localparam logic [2:0] PTR_INC    = 3'd3;
   localparam logic [2:0] PTR_DEC    = 3'd4;

   // Count operations.
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_CLR  = 2'd3;

   // Step addresses of the microprogram.
   localparam logic [PC_W-1:0] PC_DISP    = 5'd0;
   localparam logic [PC_W-1:0] PC_INS_SET = 5'd1;
   localparam logic [PC_W-1:0] PC_INS_RD  = 5'd2;
   localparam logic [PC_W-1:0] PC_INS_WR  = 5'd3;
   localparam logic [PC_W-1:0] PC_INS_PUT = 5'd4;
   localparam logic [PC_W-1:0] PC_RD_A    = 5'd5;
   localparam logic [PC_W-1:0] PC_RD_B    = 5'd6;
   localparam logic [PC_W-1:0] PC_REM_RD  = 5'd7;
   localparam logic [PC_W-1:0] PC_REM_WR  = 5'd8;
   localparam logic [PC_W-1:0] PC_REM_END = 5'd9;
   localparam logic [PC_W-1:0] PC_SW_A    = 5'd10;
   localparam logic [PC_W-1:0] PC_SW_B    = 5'd11;
   localparam logic [PC_W-1:0] PC_SW_C    = 5'd12;
   localparam logic [PC_W-1:0] PC_SW_D    = 5'd13;
   localparam logic [PC_W-1:0] PC_CLR     = 5'd14;
   localparam logic [PC_W-1:0] PC_REJECT  = 5'd15;
   localparam logic [PC_W-1:0] PC_FIN_OK  = 5'd16;

   typedef struct packed {
      logic [2:0]      nx;
      logic [1:0]      cond;
      logic [PC_W-1:0] target;
      logic [1:0]      rsel;
      logic            we;
      logic [1:0]      wsel;
      logic [1:0]      dsel;
      logic [2:0]      ptr_op;
      logic [1:0]      cnt_op;
      logic            tmp_ld;
      logic            ok;
   } ctrl_word_type;

   // Microprogram store: one control word per step.
   function automatic ctrl_word_type isle_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      cw = '0;
      case (pc)
         PC_DISP: begin
            cw.nx = NX_DISP;
         end
         PC_INS_SET: begin
            cw.ptr_op = PTR_LD_CNT;
         end
         PC_INS_RD: begin
            cw.nx     = NX_CJMP;
            cw.cond   = COND_EQ_IDX;
            cw.target = PC_INS_PUT;
            cw.rsel   = RA_PTR_M1;
         end
         PC_INS_WR: begin
            cw.nx     = NX_JMP;
            cw.target = PC_INS_RD;
            cw.we     = 1'b1;
            cw.wsel   = WA_PTR;
            cw.dsel   = WD_RD;
            cw.ptr_op = PTR_DEC;
         end
         PC_INS_PUT: begin
            cw.nx     = NX_FIN;
            cw.we     = 1'b1;
            cw.wsel   = WA_IDX;
            cw.dsel   = WD_WORD;
            cw.cnt_op = CNT_INC;
            cw.ok     = 1'b1;
         end
         PC_RD_A: begin
            cw.rsel   = RA_IDX;
            cw.ptr_op = PTR_LD_IDX;
         end
         PC_RD_B: begin
            cw.nx     = NX_CJMP;
            cw.cond   = COND_IS_READ;
            cw.target = PC_FIN_OK;
            cw.tmp_ld = 1'b1;
         end
         PC_REM_RD: begin
            cw.nx     = NX_CJMP;
            cw.cond   = COND_LAST;
            cw.target = PC_REM_END;
            cw.rsel   = RA_PTR_P1;
         end
         PC_REM_WR: begin
            cw.nx     = NX_JMP;
            cw.target = PC_REM_RD;
            cw.we     = 1'b1;
            cw.wsel   = WA_PTR;
            cw.dsel   = WD_RD;
            cw.ptr_op = PTR_INC;
         end
         PC_REM_END: begin
            cw.nx     = NX_FIN;
            cw.cnt_op = CNT_DEC;
            cw.ok     = 1'b1;
         end
         PC_SW_A: begin
            cw.rsel = RA_IDX;
         end
         PC_SW_B: begin
            cw.rsel   = RA_OTH;
            cw.tmp_ld = 1'b1;
         end
         PC_SW_C: begin
            cw.we   = 1'b1;
            cw.wsel = WA_IDX;
            cw.dsel = WD_RD;
         end
         PC_SW_D: begin
            cw.nx   = NX_FIN;
            cw.we   = 1'b1;
            cw.wsel = WA_OTH;
            cw.dsel = WD_TMP;
            cw.ok   = 1'b1;
         end
         PC_CLR: begin
            cw.nx     = NX_FIN;
            cw.cnt_op = CNT_CLR;
            cw.ok     = 1'b1;
         end
         PC_FIN_OK: begin
            cw.nx = NX_FIN;
            cw.ok = 1'b1;
         end
         default: begin
            cw.nx = NX_FIN;
         end
      endcase
      return cw;
   endfunction

   // First step of the routine for an accepted command.
   function automatic logic [PC_W-1:0] entry_pc(input logic [CMD_W-1:0] cmd,
                                                input logic legal);
      logic [PC_W-1:0] pc;
      pc = PC_REJECT;
      if (legal) begin
         case (cmd)
            CMD_PUSH, CMD_INSERT:         pc = PC_INS_SET;
            CMD_POP, CMD_REMOVE, CMD_READ: pc = PC_RD_A;
            CMD_SWAP:                     pc = PC_SW_A;
            CMD_CLEAR:                    pc = PC_CLR;
            default:                      pc = PC_REJECT;
         endcase
      end
      return pc;
   endfunction

endpackage

>>> rtl/indexed_stack_list_engine.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// req      | in        | req_valid/req_ready  | command, entry_index, other_index, data
// rsp      | out       | rsp_valid/rsp_ready  | read_data, ok, count
//
// One command transaction is worked at a time by a microcoded sequencer over a
// single-port-write, registered-read memory. Each moved entry of a push/insert or
// pop/remove costs one read step and one write step through the memory port. Reset
// is synchronous and clears the count and the control state only; the memory holds
// no reset value. A result waiting on rsp_ready stalls the sequencer at its final
// step, and no new request is taken until that step has completed.
module indexed_stack_list_engine #(
   parameter int DEPTH  = isle_pkg::ISLE_DEPTH,
   parameter int DATA_W = isle_pkg::ISLE_DATA_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [isle_pkg::CMD_W-1:0]      req_command,
   input  logic [$clog2(DEPTH+1)-1:0]      req_entry_index,
   input  logic [$clog2(DEPTH)-1:0]        req_other_index,
   input  logic [DATA_W-1:0]               req_entry_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [DATA_W-1:0]               rsp_read_data,
   output logic                            rsp_ok,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_count
);
   import isle_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   // Entry storage, position 0 is the top of the list.
   logic [DATA_W-1:0] mem [DEPTH];

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [ADDR_W-1:0] oth_ff;
   logic [DATA_W-1:0] word_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [DATA_W-1:0] tmp_ff;
   logic [DATA_W-1:0] rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic              rsp_ok_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   ctrl_word_type     cw;
   logic              req_go;
   logic              stall;
   logic              step_go;
   logic              fin_go;
   logic              legal;
   logic              cond_true;
   logic [CNT_W-1:0]  ptr_p1;
   logic [CNT_W-1:0]  raddr_full;
   logic [CNT_W-1:0]  waddr_full;
   logic [DATA_W-1:0] wdata;
   logic              returns_data;

   assign cw      = isle_rom(pc_ff);
   assign req_ready = !busy_ff;
   assign req_go  = req_valid && !busy_ff;

   // The final step waits while the previous result is still held.
   assign stall   = (cw.nx == NX_FIN) && rsp_valid_ff && !rsp_ready;
   assign step_go = busy_ff && !stall;
   assign fin_go  = step_go && (cw.nx == NX_FIN);

   assign ptr_p1  = ptr_ff + CNT_W'(1);

   // Legality of the held command against the current count.
   always_comb begin
      case (cmd_ff)
         CMD_PUSH, CMD_INSERT: legal = (idx_ff <= count_ff) && (count_ff < DEPTH_C);
         CMD_POP, CMD_READ, CMD_REMOVE: legal = idx_ff < count_ff;
         CMD_SWAP: legal = (idx_ff < count_ff) && (CNT_W'(oth_ff) < count_ff)
                           && (idx_ff != CNT_W'(oth_ff));
         CMD_CLEAR: legal = 1'b1;
         default:   legal = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.cond)
         COND_EQ_IDX:  cond_true = ptr_ff == idx_ff;
         COND_IS_READ: cond_true = cmd_ff == CMD_READ;
         COND_LAST:    cond_true = ptr_p1 == count_ff;
         default:      cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (step_go) begin
         case (cw.nx)
            NX_SEQ:  pc_in = pc_ff + PC_W'(1);
            NX_JMP:  pc_in = cw.target;
            NX_CJMP: pc_in = cond_true ? cw.target : pc_ff + PC_W'(1);
            NX_DISP: pc_in = entry_pc(cmd_ff, legal);
            NX_FIN:  pc_in = PC_DISP;
            default: pc_in = PC_DISP;
         endcase
      end
   end

   always_comb begin
      case (cw.rsel)
         RA_PTR_M1: raddr_full = ptr_ff - CNT_W'(1);
         RA_IDX:    raddr_full = idx_ff;
         RA_PTR_P1: raddr_full = ptr_p1;
         RA_OTH:    raddr_full = CNT_W'(oth_ff);
         default:   raddr_full = idx_ff;
      endcase
   end

   always_comb begin
      case (cw.wsel)
         WA_PTR:  waddr_full = ptr_ff;
         WA_IDX:  waddr_full = idx_ff;
         WA_OTH:  waddr_full = CNT_W'(oth_ff);
         default: waddr_full = ptr_ff;
      endcase
   end

   always_comb begin
      case (cw.dsel)
         WD_RD:   wdata = rd_ff;
         WD_WORD: wdata = word_ff;
         WD_TMP:  wdata = tmp_ff;
         default: wdata = rd_ff;
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (step_go) begin
         case (cw.ptr_op)
            PTR_LD_CNT: ptr_in = count_ff;
            PTR_LD_IDX: ptr_in = idx_ff;
            PTR_INC:    ptr_in = ptr_p1;
            PTR_DEC:    ptr_in = ptr_ff - CNT_W'(1);
            default:    ptr_in = ptr_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (step_go) begin
         case (cw.cnt_op)
            CNT_INC: count_in = count_ff + CNT_W'(1);
            CNT_DEC: count_in = count_ff - CNT_W'(1);
            CNT_CLR: count_in = '0;
            default: count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_go) begin
         busy_in = 1'b1;
      end else if (fin_go) begin
         busy_in = 1'b0;
      end
   end

   assign rsp_valid_in = fin_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Only pop and read return the captured word; everything else returns zero.
   assign returns_data = cw.ok && ((cmd_ff == CMD_POP) || (cmd_ff == CMD_READ));

   // Memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (step_go && cw.we) begin
         mem[waddr_full[ADDR_W-1:0]] <= wdata;
      end
      rd_ff <= mem[raddr_full[ADDR_W-1:0]];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_DISP;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; push and pop always work at the top.
   always_ff @(posedge clock) begin
      if (req_go) begin
         cmd_ff  <= req_command;
         idx_ff  <= ((req_command == CMD_PUSH) || (req_command == CMD_POP)) ?
                    '0 : req_entry_index;
         oth_ff  <= req_other_index;
         word_ff <= req_entry_data;
      end
      ptr_ff <= ptr_in;
      if (step_go && cw.tmp_ld) begin
         tmp_ff <= rd_ff;
      end
      if (fin_go) begin
         rsp_read_data_ff <= returns_data ? tmp_ff : '0;
         rsp_ok_ff        <= cw.ok;
         rsp_count_ff     <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_count     = rsp_count_ff;

`ifndef SYNTHESIS
   // The stored count can never pass the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count exceeds capacity");

   // An idle sequencer always rests at the dispatch step.
   a_idle_pc: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pc_ff == PC_DISP)
      else $error("sequencer left dispatch while idle");

   // Memory writes stay within the occupied part of the list plus one.
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (step_go && cw.we) |-> waddr_full <= count_ff)
      else $error("memory write beyond list end");

   // A completed clear leaves an empty list.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (fin_go && cw.ok && cmd_ff == CMD_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the list");
`endif

endmodule
